### rtl/core/uer_pkg.sv
// shared types and constants for the ultrasonic echo ranger
// no dependencies; imported by every module of the block
`default_nettype none

package uer_pkg;

  // command codes carried in the low bits of the input beat
  typedef enum logic [1:0] {
    CMD_START   = 2'd0,
    CMD_CAPTURE = 2'd1,
    CMD_TICK    = 2'd2
  } cmd_e;

  // configuration register indexes
  typedef enum logic {
    REG_TIMEOUT = 1'b0,
    REG_SCALE   = 1'b1
  } reg_e;

  localparam int PORTS     = 4;   // channels the 2-bit channel field can address
  localparam int TICK_W    = 16;
  localparam int DIST_W    = 24;
  localparam int WAIT_W    = 10;
  localparam int SCALE_W   = 16;
  localparam int QDEPTH    = 4;
  localparam int QAW       = $clog2(QDEPTH);
  localparam int QCW       = $clog2(QDEPTH + 1);

  localparam logic [WAIT_W-1:0]  TIMEOUT_RST = 10'd100;
  localparam logic [SCALE_W-1:0] SCALE_RST   = 16'd1124;

  // results caused by one input item: either one measurement or a set of timeouts
  typedef struct packed {
    logic               timeout;
    logic [1:0]         sensor;
    logic [TICK_W-1:0]  ticks;
    logic [DIST_W-1:0]  dist_q8;
    logic [PORTS-1:0]   tmask;
  } bundle_t;

endpackage

`default_nettype wire

### rtl/core/uer_core.sv
// input register, per-channel state and single-pass result logic
// depends on uer_pkg
`default_nettype none

module uer_core import uer_pkg::*; #(
  parameter int CHANNELS     = 4,
  parameter int COUNTER_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [23:0]        s_tdata,
  input  wire logic               q_full,
  output logic                    push,
  output bundle_t                 bundle
);

  localparam int NCH = (CHANNELS < PORTS) ? CHANNELS : PORTS;
  localparam int DW  = (COUNTER_BITS > TICK_W) ? COUNTER_BITS : TICK_W;
  localparam logic [DW-1:0] CNT_MASK = {DW{1'b1}} >> (DW - COUNTER_BITS);
  localparam logic [DW-1:0] TICK_MAX = DW'({TICK_W{1'b1}});

  logic [WAIT_W-1:0]  timeout_ms;
  logic [SCALE_W-1:0] scale_q16;

  logic               ir_v;
  logic [1:0]         ir_cmd;
  logic [1:0]         ir_ch;
  logic [TICK_W-1:0]  ir_ts;

  logic [NCH-1:0]     phase, phase_next;
  logic [NCH-1:0]     armed, armed_next;
  logic [WAIT_W-1:0]  wait_count [NCH];
  logic [WAIT_W-1:0]  wait_count_next [NCH];
  logic [DW-1:0]      start_stamp [NCH];
  logic [DW-1:0]      start_stamp_next [NCH];

  logic               adv;
  logic               cap_hit;
  logic [DW-1:0]      cap_stamp;
  logic [PORTS-1:0]   tmask;
  logic [DW-1:0]      ts_m;
  logic [DW-1:0]      diff;
  logic [TICK_W-1:0]  ticks;
  logic [31:0]        prod;

  assign adv      = ir_v && !q_full;
  assign s_tready = !ir_v || adv;
  assign ts_m     = DW'(ir_ts) & CNT_MASK;

  always_comb begin
    phase_next       = phase;
    armed_next       = armed;
    wait_count_next  = wait_count;
    start_stamp_next = start_stamp;
    cap_hit          = 1'b0;
    cap_stamp        = '0;
    tmask            = '0;
    for (int c = 0; c < NCH; c++) begin
      case (ir_cmd)
        CMD_START: begin
          if (ir_ch == 2'(c)) begin
            armed_next[c]      = 1'b1;
            wait_count_next[c] = '0;
            phase_next[c]      = 1'b0;
          end
        end
        CMD_CAPTURE: begin
          if (ir_ch == 2'(c)) begin
            if (!phase[c]) begin
              start_stamp_next[c] = ts_m;
              phase_next[c]       = 1'b1;
            end else begin
              phase_next[c] = 1'b0;
              if (armed[c]) begin
                armed_next[c] = 1'b0;
                cap_hit       = 1'b1;
                cap_stamp     = start_stamp[c];
              end
            end
          end
        end
        CMD_TICK: begin
          if (armed[c]) begin
            if (wait_count[c] >= timeout_ms) begin
              tmask[c]      = 1'b1;
              armed_next[c] = 1'b0;
            end else begin
              wait_count_next[c] = wait_count[c] + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // echo width, saturated to 16 bits when the counter is wider
  assign diff  = (ts_m - cap_stamp) & CNT_MASK;
  assign ticks = (diff > TICK_MAX) ? {TICK_W{1'b1}} : diff[TICK_W-1:0];
  assign prod  = 32'(ticks) * 32'(scale_q16);

  always_comb begin
    bundle.timeout = (ir_cmd == CMD_TICK);
    bundle.sensor  = ir_ch;
    bundle.ticks   = cap_hit ? ticks : '0;
    bundle.dist_q8 = cap_hit ? prod[31:8] : '0;
    bundle.tmask   = tmask;
  end

  assign push = adv && (cap_hit || (|tmask));

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ms <= TIMEOUT_RST;
      scale_q16  <= SCALE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TIMEOUT: timeout_ms <= cfg_data[WAIT_W-1:0];
        REG_SCALE:   scale_q16  <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ir_v <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      ir_v <= 1'b1;
    end else if (adv) begin
      ir_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      ir_cmd <= s_tdata[1:0];
      ir_ch  <= s_tdata[3:2];
      ir_ts  <= s_tdata[19:4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
      armed <= '0;
      for (int c = 0; c < NCH; c++) begin
        wait_count[c]  <= '0;
        start_stamp[c] <= '0;
      end
    end else if (adv) begin
      phase       <= phase_next;
      armed       <= armed_next;
      wait_count  <= wait_count_next;
      start_stamp <= start_stamp_next;
    end
  end

endmodule

`default_nettype wire

### rtl/core/uer_queue.sv
// result bundle queue and output beat unpacker
// depends on uer_pkg
`default_nettype none

module uer_queue import uer_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  input  wire bundle_t     bundle,
  output logic             q_full,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // sensor[1:0], echo_ticks[17:2], distance_q8[41:18], zero pad
  output logic             m_tuser,   // status
  output logic             m_tlast
);

  bundle_t           q [QDEPTH];
  logic [QAW-1:0]    rd_ptr, wr_ptr;
  logic [QCW-1:0]    count;
  logic [PORTS-1:0]  sent;

  bundle_t           head;
  logic [PORTS-1:0]  rem, low;
  logic [1:0]        idx;
  logic              beat, pop;

  assign head     = q[rd_ptr];
  assign rem      = head.tmask & ~sent;
  assign low      = rem & (~rem + 1'b1);
  assign q_full   = (count == QCW'(QDEPTH));
  assign m_tvalid = (count != '0);
  assign m_tlast  = head.timeout ? ((rem & (rem - 1'b1)) == '0) : 1'b1;
  assign beat     = m_tvalid && m_tready;
  assign pop      = beat && m_tlast;

  always_comb begin
    idx = '0;
    for (int i = PORTS - 1; i >= 0; i--) begin
      if (rem[i]) idx = 2'(i);
    end
  end

  assign m_tuser = head.timeout;
  assign m_tdata = {6'd0, head.dist_q8, head.ticks, head.timeout ? idx : head.sensor};

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
      sent   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + QCW'(push) - QCW'(pop);
      if (pop) begin
        sent <= '0;
      end else if (beat) begin
        sent <= sent | low;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/core/ultrasonic_echo_ranger.sv
// four-channel ultrasonic echo timer, top level
// depends on uer_pkg, uer_core and uer_queue
//
// usage:
//   slave beat (s_tvalid/s_tready/s_tdata) carries one command: start arms a
//   channel, capture marks an echo edge with its timer stamp, tick is the
//   millisecond time base that ages armed channels
//   master beat (m_tvalid/m_tready/m_tdata/m_tuser/m_tlast) carries one
//   result: a finished measurement (width and distance) or a timeout; m_tlast
//   marks the final result of the command that caused it
//   cfg_we writes timeout_ms (index 0) or scale_q16 (index 1) from cfg_data;
//   the user must write only while the block is idle; the block does not enforce it
// path: a command beat is captured in the input register, and its results are
//   then written into the result queue and offered from there; a full queue
//   holds the command in the input register
// throughput: one command per cycle while the queue is not full; a tick that
//   times out k channels needs k output beats, one per cycle while m_tready is high
// the result queue holds four commands' worth of results; when it fills,
//   the input register holds its command and s_tready drops until
//   the receiver takes beats again
// reset: all channels disarmed, phase awaiting rising edge, counts cleared,
//   timeout_ms back to 100 and scale_q16 back to 1124, queue emptied
`default_nettype none

module ultrasonic_echo_ranger import uer_pkg::*; #(
  parameter int CHANNELS     = 4,
  parameter int COUNTER_BITS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // configuration write port
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [15:0]  cfg_data,
  // command stream
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [23:0]  s_tdata,    // cmd[1:0], channel[3:2], timestamp[19:4], zero pad
  // result stream
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [47:0]       m_tdata,    // sensor[1:0], echo_ticks[17:2], distance_q8[41:18], zero pad
  output logic              m_tuser,    // status: 0 done, 1 timeout
  output logic              m_tlast
);

  logic    q_full;
  logic    push;
  bundle_t bundle;

  // channel state and the single-pass update/measurement logic
  uer_core #(
    .CHANNELS     (CHANNELS),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .q_full    (q_full),
    .push      (push),
    .bundle    (bundle)
  );

  // result queue, unpacks timeout sets into one beat per channel
  uer_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .bundle   (bundle),
    .q_full   (q_full),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // never write into a full queue
  a_no_push_full : assert property (@(posedge clk) disable iff (rst) push |-> !q_full)
    else $error("result pushed into full queue");

  // timeout beats carry zero width and distance
  a_timeout_zero : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[41:2] == 40'd0))
    else $error("timeout beat with nonzero payload");

  // queue is empty right after reset
  a_reset_empty : assert property (@(posedge clk) $past(rst) |-> !m_tvalid)
    else $error("result offered right after reset");

  // measurement beats are always the last of their command
  a_done_last : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |-> m_tlast)
    else $error("measurement beat not marked last");

endmodule

`default_nettype wire
